// ----- rtl/core/ptrs_pkg.sv -----
// ============================================================================
// ptrs_pkg
// Shared types and constants for the periodic task release scheduler.
// ============================================================================
package ptrs_pkg;

    // Number of task slots that the register map can describe.
    localparam int MAX_SLOTS     = 8;
    localparam int DEF_SLOTS     = 8;
    localparam int PERIOD_W      = 16;
    localparam int FRAME_W       = 16;
    localparam int PRESCALE_W    = 8;
    localparam int MASK_W        = 8;
    localparam int DIV_CNT_W     = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 5;

    // Reset value of the tick divide register.
    localparam logic [PRESCALE_W-1:0] TICK_DIVIDE_RESET = 8'd1;

    // Register indexes (byte address bits 4:3).
    typedef enum logic [1:0] {
        REG_TICK_DIVIDE  = 2'd0,
        REG_TASK_ENABLE  = 2'd1,
        REG_PERIOD_LOW   = 2'd2,
        REG_PERIOD_HIGH  = 2'd3
    } ptrs_reg_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLOT,
        ST_DIV,
        ST_DONE
    } ptrs_state_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [PRESCALE_W-1:0]  tick_divide;
        logic [MASK_W-1:0]      task_enable;
        logic [CFG_DATA_W-1:0]  period_low;
        logic [CFG_DATA_W-1:0]  period_high;
    } ptrs_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic item_accept;
        logic div_load;
        logic div_step;
        logic slot_next;
        logic out_load;
    } ptrs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_hit;
        logic slot_active;
        logic slot_last;
        logic div_last;
        logic out_free;
    } ptrs_status_t;

endpackage

// ----- rtl/core/ptrs_regs.sv -----
// ============================================================================
// ptrs_regs
// Configuration register file behind the APB-style port.
// ============================================================================
module ptrs_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptrs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ptrs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ptrs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ptrs_pkg::ptrs_cfg_t                 cfg
);
    import ptrs_pkg::*;

    logic [PRESCALE_W-1:0]  tick_divide_reg;
    logic [MASK_W-1:0]      task_enable_reg;
    logic [CFG_DATA_W-1:0]  period_low_reg;
    logic [CFG_DATA_W-1:0]  period_high_reg;
    logic                   wr_en;
    ptrs_reg_t              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = ptrs_reg_t'(paddr[4:3]);

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divide_reg <= TICK_DIVIDE_RESET;
            task_enable_reg <= '0;
            period_low_reg  <= '0;
            period_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_TICK_DIVIDE: tick_divide_reg <= pwdata[PRESCALE_W-1:0];
                REG_TASK_ENABLE: task_enable_reg <= pwdata[MASK_W-1:0];
                REG_PERIOD_LOW:  period_low_reg  <= pwdata;
                REG_PERIOD_HIGH: period_high_reg <= pwdata;
                default:         ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (reg_sel)
            REG_TICK_DIVIDE: prdata = {{(CFG_DATA_W-PRESCALE_W){1'b0}}, tick_divide_reg};
            REG_TASK_ENABLE: prdata = {{(CFG_DATA_W-MASK_W){1'b0}}, task_enable_reg};
            REG_PERIOD_LOW:  prdata = period_low_reg;
            REG_PERIOD_HIGH: prdata = period_high_reg;
            default:         prdata = '0;
        endcase
    end

    assign cfg.tick_divide = tick_divide_reg;
    assign cfg.task_enable = task_enable_reg;
    assign cfg.period_low  = period_low_reg;
    assign cfg.period_high = period_high_reg;

endmodule

// ----- rtl/core/ptrs_ctrl.sv -----
// ============================================================================
// ptrs_ctrl
// Sequencer: accepts a word, walks the slots on a scheduler tick, runs the divider and hands
// the result to the output register.
// ============================================================================
module ptrs_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  ptrs_pkg::ptrs_status_t  status,
    output ptrs_pkg::ptrs_cmd_t     cmd
);
    import ptrs_pkg::*;

    ptrs_state_t state_reg;
    ptrs_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.item_accept = 1'b1;
                    state_next      = status.frame_hit ? ST_SLOT : ST_DONE;
                end
            end
            ST_SLOT:
            begin
                if (status.slot_active)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    cmd.slot_next = 1'b1;
                    if (status.slot_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    cmd.slot_next = 1'b1;
                    state_next    = status.slot_last ? ST_DONE : ST_SLOT;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ptrs_dp.sv -----
// ============================================================================
// ptrs_dp
// Datapath: prescaler, frame counter, bit-serial remainder unit, due mask
// accumulator and output register.
// ============================================================================
module ptrs_dp
#(
    parameter int TASK_SLOTS = ptrs_pkg::DEF_SLOTS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_event,
    input  ptrs_pkg::ptrs_cfg_t                 cfg,
    input  ptrs_pkg::ptrs_cmd_t                 cmd,
    output ptrs_pkg::ptrs_status_t              status,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ptrs_pkg::MASK_W-1:0]         due_mask,
    output logic                                frame_tick,
    output logic [ptrs_pkg::FRAME_W-1:0]        frame_count
);
    import ptrs_pkg::*;

    localparam logic [2:0] LAST_SLOT = 3'(TASK_SLOTS - 1);

    logic [PRESCALE_W-1:0]      prescale_reg;
    logic [PRESCALE_W-1:0]      prescale_dec;
    logic [FRAME_W-1:0]         frame_counter_reg;
    logic [2:0]                 slot_reg;
    logic [MASK_W-1:0]          work_mask_reg;
    logic                       work_frame_reg;
    logic [PERIOD_W-1:0]        rem_reg;
    logic [PERIOD_W-1:0]        rem_next;
    logic [PERIOD_W-1:0]        dividend_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;
    logic [PERIOD_W:0]          trial;
    logic [PERIOD_W-1:0]        period_sel;
    logic [2*CFG_DATA_W-1:0]    period_all;
    logic                       out_valid_reg;
    logic [MASK_W-1:0]          due_mask_reg;
    logic                       frame_tick_reg;
    logic [FRAME_W-1:0]         frame_count_reg;

    // Prescaler decrement and frame completion test.
    assign prescale_dec = prescale_reg - 1'b1;

    // Period of the slot under test.
    assign period_all = {cfg.period_high, cfg.period_low};
    assign period_sel = period_all[slot_reg*PERIOD_W +: PERIOD_W];

    // One restoring remainder step: shift in the next dividend bit.
    assign trial    = {rem_reg, dividend_reg[PERIOD_W-1]};
    assign rem_next = (trial >= {1'b0, period_sel}) ? PERIOD_W'(trial - {1'b0, period_sel})
                                                    : trial[PERIOD_W-1:0];

    assign status.frame_hit   = tick_event && (prescale_dec == '0);
    assign status.slot_active = cfg.task_enable[slot_reg] && (period_sel != '0);
    assign status.slot_last   = (slot_reg == LAST_SLOT);
    assign status.div_last    = (div_cnt_reg == {DIV_CNT_W{1'b1}});
    assign status.out_free    = !out_valid_reg || !out_stall;

    // Prescaler and frame counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg      <= TICK_DIVIDE_RESET;
            frame_counter_reg <= '0;
        end
        else if (cmd.item_accept && tick_event)
        begin
            if (prescale_dec == '0)
            begin
                prescale_reg      <= cfg.tick_divide;
                frame_counter_reg <= frame_counter_reg + 1'b1;
            end
            else
            begin
                prescale_reg <= prescale_dec;
            end
        end
    end

    // Slot walk, remainder unit and due mask accumulation.
    always_ff @(posedge clk)
    begin
        if (cmd.item_accept)
        begin
            slot_reg       <= '0;
            work_mask_reg  <= '0;
            work_frame_reg <= status.frame_hit;
        end
        else
        begin
            if (cmd.div_step && status.div_last && (rem_next == '0))
            begin
                work_mask_reg[slot_reg] <= 1'b1;
            end
            if (cmd.slot_next)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end

        if (cmd.div_load)
        begin
            rem_reg      <= '0;
            dividend_reg <= frame_counter_reg;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg      <= rem_next;
            dividend_reg <= {dividend_reg[PERIOD_W-2:0], 1'b0};
            div_cnt_reg  <= div_cnt_reg + 1'b1;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            due_mask_reg    <= work_mask_reg;
            frame_tick_reg  <= work_frame_reg;
            frame_count_reg <= frame_counter_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign due_mask    = due_mask_reg;
    assign frame_tick  = frame_tick_reg;
    assign frame_count = frame_count_reg;

endmodule

// ----- rtl/core/periodic_task_release_scheduler_top.sv -----
// A word without a scheduler tick goes from acceptance to the done state; its result is
// loaded into the output register once the output is free. A word that completes a scheduler
// tick walks all slots and runs the 16-step bit-serial remainder unit per active slot.
// Throughput: one word in flight; the next word is accepted once its result is loaded.
// Reset: rst_n is asynchronous and active low; it clears the registers to their reset
// values, the prescaler to 1, the frame counter to 0 and the output to empty.
// ============================================================================
// periodic_task_release_scheduler_top
// Divides timer ticks into scheduler ticks and reports the enabled task slots whose
// period divides the frame counter.
// ============================================================================
module periodic_task_release_scheduler_top
#(
    parameter int TASK_SLOTS = ptrs_pkg::DEF_SLOTS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                tick_event,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ptrs_pkg::MASK_W-1:0]         due_mask,
    output logic                                frame_tick,
    output logic [ptrs_pkg::FRAME_W-1:0]        frame_count,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptrs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ptrs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ptrs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ptrs_pkg::*;

    ptrs_cfg_t      cfg;
    ptrs_cmd_t      cmd;
    ptrs_status_t   status;

    // Configuration registers.
    ptrs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    ptrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    ptrs_dp #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_event  (tick_event),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .due_mask    (due_mask),
        .frame_tick  (frame_tick),
        .frame_count (frame_count)
    );

endmodule

// ----- rtl/core/ptrs_checker.sv -----
// ============================================================================
// ptrs_checker
// Port-level checks for the periodic task release scheduler.
// ============================================================================
module ptrs_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [ptrs_pkg::MASK_W-1:0]     due_mask,
    input  logic                            frame_tick,
    input  logic [ptrs_pkg::FRAME_W-1:0]    frame_count
);
    import ptrs_pkg::*;

    // A stalled result word stays valid.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(due_mask) && $stable(frame_tick)
                                   && $stable(frame_count))
        else $error("result word changed while stalled");

    // Only a completed scheduler tick can release tasks.
    a_mask_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_tick |-> due_mask == '0)
        else $error("due mask set without a scheduler tick");

    // One word is worked on at a time.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while one is in flight");

endmodule

bind periodic_task_release_scheduler_top ptrs_checker u_ptrs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .due_mask    (due_mask),
    .frame_tick  (frame_tick),
    .frame_count (frame_count)
);
